FILE: src/binary_cross_morphology_defines.svh
`ifndef BINARY_CROSS_MORPHOLOGY_DEFINES_SVH
`define BINARY_CROSS_MORPHOLOGY_DEFINES_SVH

// same-cycle implication, sampled on clk_i, off while rst_ni is low
`define BCM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, off while rst_ni is low
`define BCM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/bcm_pkg.sv
package bcm_pkg;

  // config port
  localparam int CFG_AW = 4;
  localparam int CFG_DW = 32;
  localparam int SIZE_W = 11;

  // output queue
  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_AW    = 3;
  localparam int FIFO_CW    = 4;
  // beats that can sit in the two stages before reaching the queue
  localparam int PIPE_SLOTS = 4;

  typedef enum logic [1:0] {
    REG_FRAME_WIDTH  = 2'd0,
    REG_FRAME_HEIGHT = 2'd1,
    REG_MORPH_MODE   = 2'd2
  } bcm_reg_e;

  typedef enum logic [1:0] {
    MODE_DILATE = 2'd0,
    MODE_ERODE  = 2'd1,
    MODE_OPEN   = 2'd2,
    MODE_CLOSE  = 2'd3
  } bcm_mode_e;

  // one beat between stages: tick marks a stream beat, valid a pixel
  typedef struct packed {
    logic tick;
    logic valid;
    logic black;
    logic eor;
    logic eof;
  } bcm_beat_t;

  // result pixel as queued for the output
  typedef struct packed {
    logic end_of_frame;
    logic end_of_row;
    logic out_black;
  } bcm_pix_t;

endpackage

FILE: src/bcm_ram.sv
module bcm_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_a_q;
  logic [WIDTH-1:0] rdata_b_q;

  // read-first: a read of the address being written returns the old word
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_q <= mem_q[raddr_a_i];
    rdata_b_q <= mem_q[raddr_b_i];
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

FILE: src/bcm_stage.sv
`include "binary_cross_morphology_defines.svh"

module bcm_stage #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024,
  localparam int CW = $clog2(MAX_WIDTH),
  localparam int RW = $clog2(MAX_HEIGHT + 1),
  localparam int AW = $clog2(2 * MAX_WIDTH)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              restart_i,
  input  logic              dilate_i,
  input  logic [CW-1:0]     width_m1_i,
  input  logic [RW-1:0]     height_i,
  input  logic [AW-1:0]     up_off_i,
  input  bcm_pkg::bcm_beat_t in_i,
  output bcm_pkg::bcm_beat_t out_o
);

  import bcm_pkg::*;

  localparam int OK_UP    = 0;
  localparam int OK_LEFT  = 1;
  localparam int OK_RIGHT = 2;
  localparam int OK_DOWN  = 3;

  logic [CW-1:0] jc_q, jc_d;
  logic [RW-1:0] jr_q, jr_d;
  logic [AW-1:0] wp_q, wp_d;

  logic          drain, last_col, act, store;
  logic [AW-1:0] raddr_r, raddr_u;
  logic          rd_r, rd_u;

  logic          s1_tick_q, s1_act_q, s1_emit_q;
  logic          s1_down_q, s1_fwd_q, s1_eor_q, s1_eof_q;
  logic [3:0]    s1_ok_q;
  logic          ctr_q, lft_q;
  logic          right, res;
  bcm_beat_t     out_q;

  // jr counts input rows, jr == height means the frame is in and rows drain
  always_comb begin
    drain    = (jr_q == height_i);
    last_col = (jc_q == width_m1_i);
    act      = in_i.tick && (drain || in_i.valid);
    store    = act && !drain;
    raddr_r  = wp_q - AW'(width_m1_i);
    raddr_u  = wp_q - up_off_i;

    jc_d = jc_q;
    jr_d = jr_q;
    wp_d = wp_q;
    if (restart_i) begin
      jc_d = '0;
      jr_d = '0;
      wp_d = '0;
    end else if (act) begin
      if (last_col) begin
        jc_d = '0;
        if (drain) begin
          jr_d = '0;
          wp_d = '0;
        end else begin
          jr_d = jr_q + RW'(1);
          wp_d = wp_q + AW'(1);
        end
      end else begin
        jc_d = jc_q + CW'(1);
        wp_d = wp_q + AW'(1);
      end
    end
  end

  bcm_ram #(
    .WIDTH (1),
    .DEPTH (2 ** AW)
  ) u_rows (
    .clk_i     (clk_i),
    .we_i      (store),
    .waddr_i   (wp_q),
    .wdata_i   (in_i.black),
    .raddr_a_i (raddr_r),
    .rdata_a_o (rd_r),
    .raddr_b_i (raddr_u),
    .rdata_b_o (rd_u)
  );

  // one-pixel rows read back the pixel written in the same beat
  always_comb begin
    right = s1_fwd_q ? s1_down_q : rd_r;
    if (dilate_i) begin
      res = ctr_q | (s1_ok_q[OK_UP] & rd_u) | (s1_ok_q[OK_LEFT] & lft_q) |
            (s1_ok_q[OK_RIGHT] & right) | (s1_ok_q[OK_DOWN] & s1_down_q);
    end else begin
      res = ctr_q & (~s1_ok_q[OK_UP] | rd_u) & (~s1_ok_q[OK_LEFT] | lft_q) &
            (~s1_ok_q[OK_RIGHT] | right) & (~s1_ok_q[OK_DOWN] | s1_down_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      jc_q      <= '0;
      jr_q      <= '0;
      wp_q      <= '0;
      s1_tick_q <= 1'b0;
      s1_act_q  <= 1'b0;
      s1_emit_q <= 1'b0;
      ctr_q     <= 1'b0;
      lft_q     <= 1'b0;
      out_q     <= '0;
    end else begin
      jc_q      <= jc_d;
      jr_q      <= jr_d;
      wp_q      <= wp_d;
      s1_tick_q <= in_i.tick;
      s1_act_q  <= act;
      s1_emit_q <= act && (jr_q != '0);
      if (s1_act_q) begin
        lft_q <= ctr_q;
        ctr_q <= right;
      end
      out_q.tick  <= s1_tick_q;
      out_q.valid <= s1_emit_q;
      out_q.black <= res;
      out_q.eor   <= s1_eor_q;
      out_q.eof   <= s1_eof_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_down_q <= in_i.black;
    s1_fwd_q  <= store && (raddr_r == wp_q);
    s1_ok_q   <= {!drain, !last_col, jc_q != '0, jr_q > RW'(1)};
    s1_eor_q  <= last_col;
    s1_eof_q  <= last_col && drain;
  end

  assign out_o = out_q;

  `BCM_ASSERT_IMP(a_col_in_range, 1'b1, jc_q <= width_m1_i, "column counter past row end")
  `BCM_ASSERT_IMP(a_emit_on_tick, out_q.valid, out_q.tick, "stage pixel without stream beat")
  `BCM_ASSERT_NXT(a_frame_wrap, act && last_col && drain,
                  (jr_q == '0) && (jc_q == '0) && (wp_q == '0), "frame end did not wrap")

endmodule

FILE: src/bcm_fifo.sv
`include "binary_cross_morphology_defines.svh"

module bcm_fifo (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     push_i,
  input  bcm_pkg::bcm_pix_t        data_i,
  input  logic                     pop_i,
  output bcm_pkg::bcm_pix_t        data_o,
  output logic                     valid_o,
  output logic [bcm_pkg::FIFO_CW-1:0] count_o
);

  import bcm_pkg::*;

  bcm_pix_t             mem_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wr_q, rd_q;
  logic [FIFO_CW-1:0]   cnt_q, cnt_d;

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + FIFO_CW'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - FIFO_CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wr_q <= wr_q + FIFO_AW'(1);
      end
      if (pop_i) begin
        rd_q <= rd_q + FIFO_AW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  assign data_o  = mem_q[rd_q];
  assign valid_o = (cnt_q != '0);
  assign count_o = cnt_q;

  `BCM_ASSERT_IMP(a_no_overflow, push_i && !pop_i, cnt_q != FIFO_CW'(FIFO_DEPTH),
                  "result queue overflow")

endmodule

FILE: src/binary_cross_morphology.sv
// path: a result beat passes each stage's s1 and out registers before the output queue;
//   opening and closing run two stages in series, dilation and erosion only one
// throughput: one beat per cycle with s_axis_tready high, set by one read-modify-write of
//   each stage's line memory per beat (two read ports, one write port); a stage emits
//   nothing for a frame's first row and needs one more row of beats (pixel or flush) to drain
// reset: asynchronous, active low; 1024 x 1024 dilation, positions zero, line
//   memories not cleared; a write to a defined register restarts the stream
module binary_cross_morphology #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,

  // pixel stream in
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [0] pixel_black
  input  logic        s_axis_tuser,   // [0] req_type (1 = flush)

  // pixel stream out
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [0] out_black
  output logic        m_axis_tlast,   // end_of_row
  output logic        m_axis_tuser,   // [0] end_of_frame

  // register port
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [bcm_pkg::CFG_AW-1:0] paddr,
  input  logic [bcm_pkg::CFG_DW-1:0] pwdata,
  output logic [bcm_pkg::CFG_DW-1:0] prdata,
  output logic                       pready
);

  import bcm_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT + 1);
  localparam int AW = $clog2(2 * MAX_WIDTH);
  // geometry after reset, clamped to the build limits
  localparam int RST_W = (1024 > MAX_WIDTH) ? MAX_WIDTH : 1024;
  localparam int RST_H = (1024 > MAX_HEIGHT) ? MAX_HEIGHT : 1024;

  // raw register values, read back as written
  logic [SIZE_W-1:0] width_q, height_q;
  bcm_mode_e         mode_q;

  // clamped geometry as the stages use it
  logic [CW-1:0] width_m1_q, width_m1_d;
  logic [RW-1:0] rows_q, rows_d;
  logic [AW-1:0] up_off_q, up_off_d;

  logic        cfg_we, restart;
  bcm_reg_e    reg_idx;
  int unsigned eff_w, eff_h;

  logic        first_dilates, two_stage;
  logic        in_beat;
  bcm_beat_t   s1_in, s1_out, s2_in, s2_out, res_beat;
  bcm_pix_t    fifo_in, fifo_out;
  logic        fifo_valid, fifo_pop;
  logic [FIFO_CW-1:0] fifo_cnt;

  // ---------------------------------------------------------------------------
  // register port: write at the access phase, no wait states
  // ---------------------------------------------------------------------------
  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite && pready;
  assign reg_idx = bcm_reg_e'(paddr[3:2]);

  // clamp a written size to 1..limit; a zero size acts as one
  always_comb begin
    eff_w = 32'(pwdata[SIZE_W-1:0]);
    if (eff_w == 0) begin
      eff_w = 1;
    end
    if (eff_w > MAX_WIDTH) begin
      eff_w = MAX_WIDTH;
    end
    eff_h = 32'(pwdata[SIZE_W-1:0]);
    if (eff_h == 0) begin
      eff_h = 1;
    end
    if (eff_h > MAX_HEIGHT) begin
      eff_h = MAX_HEIGHT;
    end
    width_m1_d = CW'(eff_w - 1);
    up_off_d   = AW'(2 * eff_w);
    rows_d     = RW'(eff_h);
  end

  // a write to a defined register restarts both stages
  always_comb begin
    case (reg_idx)
      REG_FRAME_WIDTH:  restart = cfg_we;
      REG_FRAME_HEIGHT: restart = cfg_we;
      REG_MORPH_MODE:   restart = cfg_we;
      default:          restart = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q    <= SIZE_W'(1024);
      height_q   <= SIZE_W'(1024);
      mode_q     <= MODE_DILATE;
      width_m1_q <= CW'(RST_W - 1);
      up_off_q   <= AW'(2 * RST_W);
      rows_q     <= RW'(RST_H);
    end else if (cfg_we) begin
      case (reg_idx)
        REG_FRAME_WIDTH: begin
          width_q    <= pwdata[SIZE_W-1:0];
          width_m1_q <= width_m1_d;
          up_off_q   <= up_off_d;
        end
        REG_FRAME_HEIGHT: begin
          height_q <= pwdata[SIZE_W-1:0];
          rows_q   <= rows_d;
        end
        REG_MORPH_MODE: begin
          mode_q <= bcm_mode_e'(pwdata[1:0]);
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_FRAME_WIDTH:  prdata = CFG_DW'(width_q);
      REG_FRAME_HEIGHT: prdata = CFG_DW'(height_q);
      REG_MORPH_MODE:   prdata = CFG_DW'(mode_q);
      default:          prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // mode decode: opening erodes first, closing dilates first
  // ---------------------------------------------------------------------------
  assign first_dilates = (mode_q == MODE_DILATE) || (mode_q == MODE_CLOSE);
  assign two_stage     = (mode_q == MODE_OPEN) || (mode_q == MODE_CLOSE);

  // ---------------------------------------------------------------------------
  // input side: ready as long as the queue can absorb every beat in flight
  // ---------------------------------------------------------------------------
  assign s_axis_tready = (fifo_cnt <= FIFO_CW'(FIFO_DEPTH - PIPE_SLOTS - 1));
  assign in_beat       = s_axis_tvalid && s_axis_tready;

  always_comb begin
    s1_in       = '0;
    s1_in.tick  = in_beat;
    s1_in.valid = !s_axis_tuser;
    s1_in.black = s_axis_tdata[0];
  end

  bcm_stage #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_stage_a (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .restart_i  (restart),
    .dilate_i   (first_dilates),
    .width_m1_i (width_m1_q),
    .height_i   (rows_q),
    .up_off_i   (up_off_q),
    .in_i       (s1_in),
    .out_o      (s1_out)
  );

  // second stage sees every stream beat so it can drain on any of them,
  // and stays still in the single-pass modes
  always_comb begin
    s2_in      = s1_out;
    s2_in.tick = s1_out.tick && two_stage;
  end

  bcm_stage #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_stage_b (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .restart_i  (restart),
    .dilate_i   (!first_dilates),
    .width_m1_i (width_m1_q),
    .height_i   (rows_q),
    .up_off_i   (up_off_q),
    .in_i       (s2_in),
    .out_o      (s2_out)
  );

  // ---------------------------------------------------------------------------
  // output side: queue between the stages and the downstream handshake
  // ---------------------------------------------------------------------------
  assign res_beat = two_stage ? s2_out : s1_out;

  always_comb begin
    fifo_in.out_black    = res_beat.black;
    fifo_in.end_of_row   = res_beat.eor;
    fifo_in.end_of_frame = res_beat.eof;
  end

  assign fifo_pop = fifo_valid && m_axis_tready;

  bcm_fifo u_out_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_beat.valid),
    .data_i  (fifo_in),
    .pop_i   (fifo_pop),
    .data_o  (fifo_out),
    .valid_o (fifo_valid),
    .count_o (fifo_cnt)
  );

  assign m_axis_tvalid = fifo_valid;
  assign m_axis_tdata  = {7'b0, fifo_out.out_black};
  assign m_axis_tlast  = fifo_out.end_of_row;
  assign m_axis_tuser  = fifo_out.end_of_frame;

endmodule
